// ===== design/ddtz_pkg.sv =====
// Package for the nearest-zero cluster pair remover.
// Holds the sizing constants shared by the interfaces, lanes, merge and top level.
// Depends on nothing.
package ddtz_pkg;

	localparam int MAX_LABEL    = 63;
	localparam int MAX_FEATURES = 8;
	localparam int FEATURE_BITS = 16;

	// Fixed field widths of the item and result channels.
	localparam int FEAT_FIELD_W = 16;
	localparam int LBL_W        = 6;
	localparam int CFG_W        = 4;
	localparam int NUM_FIELDS   = 8;

	// Derived sizes.
	localparam int DEPTH  = MAX_LABEL + 1;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = (LBL_W > ADDR_W) ? LBL_W : ADDR_W;
	localparam int CNT_W  = ADDR_W + 1;
	localparam int SQ_W   = 2 * FEATURE_BITS - 1;
	localparam int NORM_W = SQ_W + $clog2(MAX_FEATURES);

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_FEATURES);

	// Function codes and result kinds.
	localparam logic FUNC_ACCUM  = 1'b0;
	localparam logic FUNC_MAP    = 1'b1;
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_MAPPED = 1'b1;

endpackage

// ===== design/ddtz_ifs.sv =====
// Valid/ready channel interfaces for the item input and the result output.
// Depends on ddtz_pkg for field widths.
interface ddtz_in_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     func;
	logic signed [ddtz_pkg::FEAT_FIELD_W-1:0] feature_0;
	logic signed [ddtz_pkg::FEAT_FIELD_W-1:0] feature_1;
	logic signed [ddtz_pkg::FEAT_FIELD_W-1:0] feature_2;
	logic signed [ddtz_pkg::FEAT_FIELD_W-1:0] feature_3;
	logic signed [ddtz_pkg::FEAT_FIELD_W-1:0] feature_4;
	logic signed [ddtz_pkg::FEAT_FIELD_W-1:0] feature_5;
	logic signed [ddtz_pkg::FEAT_FIELD_W-1:0] feature_6;
	logic signed [ddtz_pkg::FEAT_FIELD_W-1:0] feature_7;
	logic        [ddtz_pkg::LBL_W-1:0]        cluster_label;
	logic                                     last_event;

	modport source (
		output valid, func, feature_0, feature_1, feature_2, feature_3,
		       feature_4, feature_5, feature_6, feature_7, cluster_label, last_event,
		input  ready
	);
	modport sink (
		input  valid, func, feature_0, feature_1, feature_2, feature_3,
		       feature_4, feature_5, feature_6, feature_7, cluster_label, last_event,
		output ready
	);
endinterface

interface ddtz_out_if;
	logic                       valid;
	logic                       ready;
	logic                       result_kind;
	logic [ddtz_pkg::LBL_W-1:0] removed_first;
	logic [ddtz_pkg::LBL_W-1:0] removed_second;
	logic [ddtz_pkg::LBL_W-1:0] mapped_label;

	modport source (
		output valid, result_kind, removed_first, removed_second, mapped_label,
		input  ready
	);
	modport sink (
		input  valid, result_kind, removed_first, removed_second, mapped_label,
		output ready
	);
endinterface

// ===== design/ddtz_ram.sv =====
// Generic single-port RAM with a registered read port.
// Depends on nothing.
module ddtz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== design/ddtz_lane.sv =====
// One feature lane: squares a signed feature exactly and registers the square.
// Depends on ddtz_pkg for widths.
module ddtz_lane (
	input  logic                                     clk,
	input  logic                                     load,
	input  logic                                     lane_on,
	input  logic signed [ddtz_pkg::FEATURE_BITS-1:0] feature,
	output logic        [ddtz_pkg::SQ_W-1:0]         sq_s1
);

	logic signed [2*ddtz_pkg::FEATURE_BITS-1:0] prod;

	// The square of a two's complement value is never negative and fits SQ_W bits.
	assign prod = feature * feature;

	always_ff @(posedge clk) begin
		if (load) begin
			sq_s1 <= lane_on ? prod[ddtz_pkg::SQ_W-1:0] : '0;
		end
	end

endmodule

// ===== design/ddtz_merge.sv =====
// Merging stage: adds the lane squares into the norm through a two-level registered tree.
// Depends on ddtz_pkg for widths and the lane count.
module ddtz_merge (
	input  logic                         clk,
	input  logic [ddtz_pkg::SQ_W-1:0]    sq_s1 [ddtz_pkg::MAX_FEATURES],
	output logic [ddtz_pkg::NORM_W-1:0]  norm_s3
);

	logic [ddtz_pkg::NORM_W-1:0] pad  [8];
	logic [ddtz_pkg::NORM_W-1:0] pair_s2 [4];

	for (genvar k = 0; k < 8; k++) begin : g_pad
		if (k < ddtz_pkg::MAX_FEATURES) begin : g_used
			assign pad[k] = ddtz_pkg::NORM_W'(sq_s1[k]);
		end else begin : g_unused
			assign pad[k] = '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < 4; p++) begin
			pair_s2[p] <= pad[2*p] + pad[2*p+1];
		end
		norm_s3 <= (pair_s2[0] + pair_s2[1]) + (pair_s2[2] + pair_s2[3]);
	end

endmodule

// ===== design/drop_two_nearest_zero_clusters.sv =====
// A map item goes straight to the output stage and is loaded into the output register once that register is free.
// An accumulate item passes through the lane squares, two adder levels, then one
// read-modify-write of the per-label minimum. A closing item then walks labels 1..highest
// from the table memory, one label a cycle, before its report goes to the output register.
// Items are worked one at a time; the output register lets the next item in while a result
// waits. After reset the table reads as all zero, no pair is chosen and eight lanes are used.
module drop_two_nearest_zero_clusters (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ddtz_pkg::CFG_W-1:0]   cfg_wdata,
	ddtz_in_if.sink                      in_ch,
	ddtz_out_if.source                   out_ch
);

	localparam int ADDR_W = ddtz_pkg::ADDR_W;
	localparam int CMP_W  = ddtz_pkg::CMP_W;
	localparam int CNT_W  = ddtz_pkg::CNT_W;
	localparam int NORM_W = ddtz_pkg::NORM_W;
	localparam int LBL_W  = ddtz_pkg::LBL_W;
	localparam int DEPTH  = ddtz_pkg::DEPTH;

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM1 = 3'd1;
	localparam logic [2:0] ST_SUM2 = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_WALK = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]                  st_q;
	logic [ddtz_pkg::CFG_W-1:0]  cfg_q;
	logic                        set_closed_q;
	logic [DEPTH-1:0]            valid_q;
	logic [ADDR_W-1:0]           highest_q;
	logic [ADDR_W-1:0]           chosen_a_q;
	logic [ADDR_W-1:0]           chosen_b_q;
	logic                        out_valid_q;

	// Item fields held while the item is worked.
	logic                        func_q;
	logic                        last_q;
	logic [LBL_W-1:0]            lbl_q;

	// Selection walk.
	logic [CNT_W-1:0]            j_q;
	logic                        pend_q;
	logic [ADDR_W-1:0]           jp_q;
	logic [ADDR_W-1:0]           i1_q;
	logic [ADDR_W-1:0]           i2_q;
	logic [NORM_W-1:0]           v1_q;
	logic [NORM_W-1:0]           v2_q;
	logic                        vld_rd_q;

	// Output register payload.
	logic                        kind_q;
	logic [LBL_W-1:0]            first_q;
	logic [LBL_W-1:0]            second_q;
	logic [LBL_W-1:0]            mapped_q;

	logic                        in_take;
	logic                        out_free;
	logic [ddtz_pkg::CFG_W-1:0]  lanes_eff;
	logic signed [ddtz_pkg::FEAT_FIELD_W-1:0] feat [ddtz_pkg::NUM_FIELDS];
	logic [ddtz_pkg::SQ_W-1:0]   sq_s1 [ddtz_pkg::MAX_FEATURES];
	logic [NORM_W-1:0]           norm_s3;

	logic [CMP_W-1:0]            lbl_ext;
	logic                        lbl_ok;
	logic [ADDR_W-1:0]           lbl_addr;

	logic                        ram_we;
	logic                        ram_re;
	logic [ADDR_W-1:0]           ram_addr;
	logic [NORM_W-1:0]           ram_rdata;
	logic [NORM_W-1:0]           stored;
	logic                        do_write;

	logic                        walk_issue;
	logic                        walk_done;
	logic [ADDR_W-1:0]           i1_n;
	logic [ADDR_W-1:0]           i2_n;
	logic [NORM_W-1:0]           v1_n;
	logic [NORM_W-1:0]           v2_n;

	logic [1:0]                  below;
	logic [LBL_W-1:0]            map_val;

	assign in_take     = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == ST_IDLE);
	assign out_free    = !out_valid_q || out_ch.ready;

	// Lanes beyond the configured count contribute nothing; counts above the lane total clamp.
	assign lanes_eff = (cfg_q > ddtz_pkg::CFG_W'(ddtz_pkg::MAX_FEATURES)) ?
		ddtz_pkg::CFG_W'(ddtz_pkg::MAX_FEATURES) : cfg_q;

	assign feat[0] = in_ch.feature_0;
	assign feat[1] = in_ch.feature_1;
	assign feat[2] = in_ch.feature_2;
	assign feat[3] = in_ch.feature_3;
	assign feat[4] = in_ch.feature_4;
	assign feat[5] = in_ch.feature_5;
	assign feat[6] = in_ch.feature_6;
	assign feat[7] = in_ch.feature_7;

	// The lanes square the features at the edge that takes the item.
	for (genvar m = 0; m < ddtz_pkg::MAX_FEATURES; m++) begin : g_lane
		ddtz_lane u_lane (
			.clk     (clk),
			.load    (in_take),
			.lane_on (ddtz_pkg::CFG_W'(m) < lanes_eff),
			.feature (feat[m][ddtz_pkg::FEATURE_BITS-1:0]),
			.sq_s1   (sq_s1[m])
		);
	end

	ddtz_merge u_merge (
		.clk     (clk),
		.sq_s1   (sq_s1),
		.norm_s3 (norm_s3)
	);

	assign lbl_ext  = CMP_W'(lbl_q);
	assign lbl_ok   = (lbl_ext <= CMP_W'(ddtz_pkg::MAX_LABEL));
	assign lbl_addr = lbl_ext[ADDR_W-1:0];

	// The minimum table: one read port shared by the update and the walk.
	// The label is read in the first adder cycle, so the data is ready for the update.
	assign walk_issue = (st_q == ST_WALK) && (j_q <= CNT_W'(highest_q));
	assign walk_done  = (st_q == ST_WALK) && !walk_issue && !pend_q;
	assign ram_re     = (st_q == ST_SUM1) || walk_issue;
	assign ram_we     = do_write;
	assign ram_addr   = (st_q == ST_WALK) ? j_q[ADDR_W-1:0] : lbl_addr;

	ddtz_ram #(
		.WIDTH (NORM_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (norm_s3),
		.rdata (ram_rdata)
	);

	// An entry not written since the set opened reads as zero, which also means unset.
	assign stored   = vld_rd_q ? ram_rdata : '0;
	assign do_write = (st_q == ST_UPD) && lbl_ok && ((stored == '0) || (norm_s3 < stored));

	// One step of the pair selection. The first two labels fill both slots; after that a
	// strictly smaller value displaces the first slot, pushing its label into the second
	// slot only when it was below the second slot's value. Ties keep the earlier label.
	always_comb begin
		i1_n = i1_q;
		i2_n = i2_q;
		v1_n = v1_q;
		v2_n = v2_q;
		if (i1_q == '0) begin
			i1_n = jp_q;
			v1_n = stored;
		end else if (i2_q == '0) begin
			i2_n = jp_q;
			v2_n = stored;
		end else if (stored < v1_q) begin
			if (v1_q < v2_q) begin
				i2_n = i1_q;
				v2_n = v1_q;
			end
			i1_n = jp_q;
			v1_n = stored;
		end else if (stored < v2_q) begin
			i2_n = jp_q;
			v2_n = stored;
		end
	end

	// Renumbering: a removed label maps to zero, the others drop by the removed labels below.
	always_comb begin
		below = 2'd0;
		if ((chosen_a_q != '0) && (CMP_W'(chosen_a_q) < lbl_ext)) begin
			below = below + 2'd1;
		end
		if ((chosen_b_q != '0) && (CMP_W'(chosen_b_q) < lbl_ext)) begin
			below = below + 2'd1;
		end
		if ((lbl_ext == '0) || (lbl_ext == CMP_W'(chosen_a_q)) ||
				(lbl_ext == CMP_W'(chosen_b_q))) begin
			map_val = '0;
		end else begin
			map_val = lbl_q - LBL_W'(below);
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			cfg_q        <= ddtz_pkg::CFG_RESET;
			set_closed_q <= 1'b0;
			valid_q      <= '0;
			highest_q    <= '0;
			chosen_a_q   <= '0;
			chosen_b_q   <= '0;
			out_valid_q  <= 1'b0;
			j_q          <= '0;
			pend_q       <= 1'b0;
			i1_q         <= '0;
			i2_q         <= '0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end

			if ((st_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (do_write) begin
				valid_q[lbl_addr] <= 1'b1;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_take) begin
						if (in_ch.func == ddtz_pkg::FUNC_MAP) begin
							st_q <= ST_OUT;
						end else begin
							// The first accumulate item of a new set empties the table.
							if (set_closed_q) begin
								valid_q      <= '0;
								highest_q    <= '0;
								set_closed_q <= 1'b0;
							end
							st_q <= ST_SUM1;
						end
					end
				end
				ST_SUM1: begin
					st_q <= ST_SUM2;
				end
				ST_SUM2: begin
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (lbl_ok && (lbl_ext > CMP_W'(highest_q))) begin
						highest_q <= lbl_addr;
					end
					if (last_q) begin
						j_q    <= CNT_W'(1);
						pend_q <= 1'b0;
						i1_q   <= '0;
						i2_q   <= '0;
						st_q   <= ST_WALK;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					pend_q <= walk_issue;
					if (walk_issue) begin
						j_q <= j_q + CNT_W'(1);
					end
					if (pend_q) begin
						i1_q <= i1_n;
						i2_q <= i2_n;
					end
					if (walk_done) begin
						chosen_a_q   <= i1_q;
						chosen_b_q   <= i2_q;
						set_closed_q <= 1'b1;
						st_q         <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q <= in_ch.func;
			last_q <= in_ch.last_event;
			lbl_q  <= in_ch.cluster_label;
		end
		if (ram_re) begin
			vld_rd_q <= valid_q[ram_addr];
			jp_q     <= ram_addr;
		end
		if ((st_q == ST_WALK) && pend_q) begin
			v1_q <= v1_n;
			v2_q <= v2_n;
		end
		if ((st_q == ST_OUT) && out_free) begin
			if (func_q == ddtz_pkg::FUNC_MAP) begin
				kind_q   <= ddtz_pkg::KIND_MAPPED;
				first_q  <= '0;
				second_q <= '0;
				mapped_q <= map_val;
			end else begin
				kind_q   <= ddtz_pkg::KIND_REPORT;
				first_q  <= LBL_W'(chosen_a_q);
				second_q <= LBL_W'(chosen_b_q);
				mapped_q <= '0;
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.result_kind    = kind_q;
	assign out_ch.removed_first  = first_q;
	assign out_ch.removed_second = second_q;
	assign out_ch.mapped_label   = mapped_q;

	// A chosen second label always comes with a distinct, non-zero first label.
	a_pair_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(chosen_b_q != '0) |-> ((chosen_a_q != '0) && (chosen_a_q != chosen_b_q)))
		else $error("second removed label without a distinct first label");

	// The walk never runs more than one step past the highest label.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WALK) |-> (j_q <= (CNT_W'(highest_q) + CNT_W'(1))))
		else $error("selection walk ran past the highest label");

	// A finished item with a free output register shows its result on the next cycle.
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_OUT) && !out_ch.valid) |=> out_ch.valid)
		else $error("result not presented after the item finished");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for drop_two_nearest_zero_clusters: directed and random items,
// predicted per accepted item and compared field by field against the result channel.
// Depends on ddtz_pkg and on the channel interfaces in ddtz_ifs.
module testbench;

	localparam int FEAT_FIELD_W = ddtz_pkg::FEAT_FIELD_W;
	localparam int FEATURE_BITS = ddtz_pkg::FEATURE_BITS;
	localparam int MAX_FEATURES = ddtz_pkg::MAX_FEATURES;
	localparam int MAX_LABEL    = ddtz_pkg::MAX_LABEL;
	localparam int LBL_W        = ddtz_pkg::LBL_W;
	localparam int CFG_W        = ddtz_pkg::CFG_W;
	localparam int NORM_W       = ddtz_pkg::NORM_W;
	localparam int DEPTH        = ddtz_pkg::DEPTH;

	// One input item as the sender holds it. The pause flag makes the sender wait until
	// every awaited result has come back before it offers this item.
	typedef struct {
		logic                              func;
		logic [7:0][FEAT_FIELD_W-1:0]      feat;
		logic [LBL_W-1:0]                  label;
		logic                              last;
		bit                                pause;
	} event_item_t;

	typedef struct packed {
		logic             kind;
		logic [LBL_W-1:0] first;
		logic [LBL_W-1:0] second;
		logic [LBL_W-1:0] mapped;
	} cluster_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	ddtz_in_if  in_ch ();
	ddtz_out_if out_ch ();

	drop_two_nearest_zero_clusters dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Predicted state of the block: smallest norm per label, highest label of the open
	// set, the chosen pair and whether the last accumulate item closed the set.
	logic [NORM_W-1:0] norm_min [DEPTH];
	logic [LBL_W-1:0]  top_label;
	logic [LBL_W-1:0]  pick_a;
	logic [LBL_W-1:0]  pick_b;
	logic              set_done;
	logic [CFG_W-1:0]  lanes_cfg;

	event_item_t     pending_items [$];
	cluster_result_t awaited_results [$];
	event_item_t     on_bus;

	int items_queued;
	int items_taken;
	int failures;
	int send_gap_pct;
	int recv_stall_pct;

	// Lane settings for the random phases, extremes included, and the idling pattern
	// that each phase uses in turn.
	int lane_plan  [8] = '{1, 15, 0, 8, 3, 5, 2, 8};
	int gap_plan   [4] = '{0, 67, 0, 17};
	int stall_plan [4] = '{0, 0, 67, 17};

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// The run is limited to a generous fixed time; a hang anywhere ends in failure.
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Square of one feature lane, taken from its low FEATURE_BITS bits as two's
	// complement. The magnitude of the most negative value still fits unsigned.
	function automatic logic [NORM_W-1:0] lane_square(input logic [FEAT_FIELD_W-1:0] f);
		logic [FEATURE_BITS-1:0] raw;
		logic [FEATURE_BITS-1:0] mag;
		logic [NORM_W-1:0]       wide;
		raw  = f[FEATURE_BITS-1:0];
		mag  = raw[FEATURE_BITS-1] ? (~raw + 1'b1) : raw;
		wide = mag;
		return wide * wide;
	endfunction

	// Walk labels 1..highest and keep the two smallest minima. Strict comparisons mean
	// that on a tie the label met first keeps its slot. When the first slot is beaten,
	// its old label only moves down if it was below the second slot's value.
	function automatic void pick_nearest_pair();
		logic [LBL_W-1:0]  i1;
		logic [LBL_W-1:0]  i2;
		logic [NORM_W-1:0] v1;
		logic [NORM_W-1:0] v2;
		logic [NORM_W-1:0] val;
		int                j;
		i1 = '0;
		i2 = '0;
		v1 = '0;
		v2 = '0;
		for (j = 1; j <= top_label && j <= MAX_LABEL; j++) begin
			val = norm_min[j];
			if (i1 == 0) begin
				i1 = LBL_W'(j);
				v1 = val;
			end else if (i2 == 0) begin
				i2 = LBL_W'(j);
				v2 = val;
			end else if (val < v1) begin
				if (v1 < v2) begin
					i2 = i1;
					v2 = v1;
				end
				i1 = LBL_W'(j);
				v1 = val;
			end else if (val < v2) begin
				i2 = LBL_W'(j);
				v2 = val;
			end
		end
		pick_a = i1;
		pick_b = i2;
	endfunction

	// Renumber a label against the current pair: removed labels give zero, the others
	// drop by the number of removed labels below them. Label zero always maps to zero.
	function automatic logic [LBL_W-1:0] renumber(input logic [LBL_W-1:0] lab);
		int below;
		below = 0;
		if (lab == 0 || lab == pick_a || lab == pick_b)
			return '0;
		if (pick_a != 0 && pick_a < lab)
			below++;
		if (pick_b != 0 && pick_b < lab)
			below++;
		return LBL_W'(lab - below);
	endfunction

	// Apply one accepted item to the predicted state and queue the result it causes.
	function automatic void predict_item(input event_item_t it);
		cluster_result_t r;
		logic [NORM_W-1:0] norm;
		int                lanes;
		int                m;
		r = '0;
		if (it.func == ddtz_pkg::FUNC_MAP) begin
			r.kind   = ddtz_pkg::KIND_MAPPED;
			r.mapped = renumber(it.label);
			awaited_results.push_back(r);
			return;
		end
		// The first accumulate item after a closing one starts a fresh set.
		if (set_done) begin
			foreach (norm_min[i])
				norm_min[i] = '0;
			top_label = '0;
			set_done  = 1'b0;
		end
		if (it.label <= MAX_LABEL) begin
			lanes = (lanes_cfg > MAX_FEATURES) ? MAX_FEATURES : lanes_cfg;
			norm  = '0;
			for (m = 0; m < lanes; m++)
				norm += lane_square(it.feat[m]);
			// A stored zero stands for an unset minimum and is always replaced.
			if (norm_min[it.label] == 0 || norm < norm_min[it.label])
				norm_min[it.label] = norm;
			if (it.label > top_label)
				top_label = it.label;
		end
		if (!it.last)
			return;
		pick_nearest_pair();
		set_done = 1'b1;
		r.kind   = ddtz_pkg::KIND_REPORT;
		r.first  = pick_a;
		r.second = pick_b;
		awaited_results.push_back(r);
	endfunction

	function automatic void push_item(input event_item_t it);
		pending_items.push_back(it);
		items_queued++;
	endfunction

	// Feature values in three flavours: a tiny pool that gives zero norms and ties,
	// the extremes of the field, and the full random range.
	function automatic logic [FEAT_FIELD_W-1:0] rand_feature(input int style);
		if (style < 3)
			return FEAT_FIELD_W'(int'($urandom_range(4)) - 2);
		if (style == 3) begin
			case ($urandom_range(3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h0000;
				default: return 16'hffff;
			endcase
		end
		return FEAT_FIELD_W'($urandom);
	endfunction

	function automatic event_item_t accum_item(input logic [LBL_W-1:0] label,
	                                           input logic last, input int style);
		event_item_t it;
		it.func  = ddtz_pkg::FUNC_ACCUM;
		it.label = label;
		it.last  = last;
		it.pause = 1'b0;
		for (int m = 0; m < 8; m++)
			it.feat[m] = rand_feature(style);
		return it;
	endfunction

	// Accumulate item with the same value in every lane, for the directed part.
	function automatic event_item_t flat_item(input logic [LBL_W-1:0] label,
	                                          input logic last,
	                                          input logic [FEAT_FIELD_W-1:0] v);
		event_item_t it;
		it.func  = ddtz_pkg::FUNC_ACCUM;
		it.label = label;
		it.last  = last;
		it.pause = 1'b0;
		it.feat  = {8{v}};
		return it;
	endfunction

	function automatic event_item_t map_item(input logic [LBL_W-1:0] label, input bit pause);
		event_item_t it;
		it.func  = ddtz_pkg::FUNC_MAP;
		it.label = label;
		it.last  = 1'b0;
		it.pause = pause;
		for (int m = 0; m < 8; m++)
			it.feat[m] = FEAT_FIELD_W'($urandom);
		return it;
	endfunction

	// One set of events with random content: most sets close normally and are followed
	// by a few map items, some leave the set open so that it runs on into the next one,
	// and now and then a stray map item turns up in the middle of a set.
	task automatic queue_cluster_set();
		int hi;
		int n_ev;
		int n_map;
		int style;
		int k;
		hi    = ($urandom_range(9) == 0) ? MAX_LABEL : $urandom_range(12, 1);
		n_ev  = $urandom_range(12, 1);
		style = $urandom_range(9);
		for (k = 0; k < n_ev; k++) begin
			push_item(accum_item(LBL_W'($urandom_range(hi)),
			                     k == n_ev - 1 && $urandom_range(9) != 0, style));
			if ($urandom_range(14) == 0)
				push_item(map_item(LBL_W'($urandom_range(MAX_LABEL)), 1'b0));
		end
		n_map = $urandom_range(5, 1);
		for (k = 0; k < n_map; k++)
			push_item(map_item(LBL_W'(($urandom_range(3) == 0) ?
			                          $urandom_range(MAX_LABEL) : $urandom_range(hi)),
			                   k == 0 && $urandom_range(19) == 0));
	endtask

	// Wait until every queued item has been taken and every result has come back, then
	// a little longer: an accumulate item without a result, or a label walk, may still
	// be under way inside the block.
	task automatic wait_quiet(input int extra);
		while (items_taken != items_queued || awaited_results.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_lanes(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lanes_cfg = v;
	endtask

	// Sender. An item is taken at an edge where valid and ready are both high; only then
	// is it predicted. A new item goes on the bus when the bus is free, unless the sender
	// idles this cycle or the next item asks to wait for all results first.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_item(on_bus);
				items_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() != 0
				    && !(pending_items[0].pause && awaited_results.size() != 0)
				    && $urandom_range(99) >= send_gap_pct) begin
					on_bus = pending_items.pop_front();
					in_ch.valid         <= 1'b1;
					in_ch.func          <= on_bus.func;
					in_ch.feature_0     <= on_bus.feat[0];
					in_ch.feature_1     <= on_bus.feat[1];
					in_ch.feature_2     <= on_bus.feat[2];
					in_ch.feature_3     <= on_bus.feat[3];
					in_ch.feature_4     <= on_bus.feat[4];
					in_ch.feature_5     <= on_bus.feat[5];
					in_ch.feature_6     <= on_bus.feat[6];
					in_ch.feature_7     <= on_bus.feat[7];
					in_ch.cluster_label <= on_bus.label;
					in_ch.last_event    <= on_bus.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			failures++;
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Receiver. Each accepted result is checked against the oldest awaited one; ready
	// is redrawn every cycle so that stalls fall at random.
	always @(posedge clk or negedge arst_n) begin
		cluster_result_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (awaited_results.size() == 0) begin
					failures++;
					$error("result with no item awaiting it: result_kind %0d",
					       out_ch.result_kind);
				end else begin
					want = awaited_results.pop_front();
					check_field("result_kind", want.kind, out_ch.result_kind);
					check_field("removed_first", want.first, out_ch.removed_first);
					check_field("removed_second", want.second, out_ch.removed_second);
					check_field("mapped_label", want.mapped, out_ch.mapped_label);
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int phase;
		int start;
		// Every input is known from time zero, with reset held low at the start.
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		in_ch.valid         = 1'b0;
		in_ch.func          = ddtz_pkg::FUNC_ACCUM;
		in_ch.feature_0     = '0;
		in_ch.feature_1     = '0;
		in_ch.feature_2     = '0;
		in_ch.feature_3     = '0;
		in_ch.feature_4     = '0;
		in_ch.feature_5     = '0;
		in_ch.feature_6     = '0;
		in_ch.feature_7     = '0;
		in_ch.cluster_label = '0;
		in_ch.last_event    = 1'b0;
		out_ch.ready        = 1'b0;
		foreach (norm_min[i])
			norm_min[i] = '0;
		top_label      = '0;
		pick_a         = '0;
		pick_b         = '0;
		set_done       = 1'b0;
		lanes_cfg      = ddtz_pkg::CFG_RESET;
		items_queued   = 0;
		items_taken    = 0;
		failures       = 0;
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset lane count. Map items before any set has closed
		// see no pair at all.
		push_item(map_item(6'd0, 1'b0));
		push_item(map_item(6'd7, 1'b0));
		push_item(map_item(6'd63, 1'b0));
		// A set holding only label zero: highest stays zero, so no label is chosen.
		push_item(flat_item(6'd0, 1'b1, 16'h8000));
		// A set reaching label one only: the first slot is filled, the second is not.
		push_item(flat_item(6'd1, 1'b1, 16'h7fff));
		push_item(map_item(6'd1, 1'b0));
		push_item(map_item(6'd2, 1'b0));
		push_item(map_item(6'd0, 1'b0));
		// A zero norm is overwritten by a later one, equal norms tie, label 63 sees the
		// largest norm the lanes allow, and most labels stay unset.
		push_item(flat_item(6'd3, 1'b0, 16'h0000));
		push_item(flat_item(6'd3, 1'b0, 16'h0002));
		push_item(flat_item(6'd5, 1'b0, 16'h0001));
		push_item(flat_item(6'd2, 1'b0, 16'hffff));
		push_item(flat_item(6'd63, 1'b0, 16'h8000));
		push_item(flat_item(6'd63, 1'b0, 16'h7fff));
		push_item(flat_item(6'd4, 1'b0, 16'h0003));
		push_item(flat_item(6'd4, 1'b1, 16'h0004));
		// The sender holds this one back until the report above has arrived.
		push_item(map_item(6'd7, 1'b1));
		push_item(map_item(6'd6, 1'b0));
		push_item(map_item(6'd63, 1'b0));

		// Random phases: the lane count changes only while the block is quiet, and each
		// phase takes the next idling pattern, the first with no idling at all.
		for (phase = 0; phase < 8; phase++) begin
			wait_quiet(100);
			send_gap_pct   = gap_plan[phase % 4];
			recv_stall_pct = stall_plan[phase % 4];
			write_lanes(CFG_W'(lane_plan[phase]));
			start = items_queued;
			while (items_queued - start < 165)
				queue_cluster_set();
		end

		wait_quiet(120);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
